// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int unsigned FRAME_LEN   = 23;
	localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
	localparam int unsigned CRC_BYTES   = 21;
	localparam int unsigned POS_W       = 5;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	localparam logic [POS_W-1:0] POS_SAT   = POS_W'(FRAME_LEN + 1);
	localparam logic [POS_W-1:0] POS_FINAL = POS_W'(FRAME_LEN - 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FRAME_TYPE    = 8'd2;
	localparam logic [7:0] FRAME_VERSION = 8'd1;
	localparam logic [7:0] SEQ_WINDOW    = 8'd128;

	localparam logic [2:0] STATUS_OK      = 3'd0;
	localparam logic [2:0] STATUS_BAD_LEN = 3'd1;
	localparam logic [2:0] STATUS_BAD_ID  = 3'd2;
	localparam logic [2:0] STATUS_BAD_SEQ = 3'd3;
	localparam logic [2:0] STATUS_BAD_CRC = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  seq_number;
		logic [7:0]  flag_bits;
		logic [31:0] time_seconds;
		logic [31:0] time_micros;
		logic [15:0] arm_position;
		logic [15:0] arm_speed;
		logic [15:0] arm_effort;
		logic [7:0]  motor_current;
		logic [7:0]  temperature_raw;
		logic [7:0]  supply_voltage;
	} result_item_t;

	// reflected CRC-16, one byte, bitwise
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/status_frame_receiver.sv
`timescale 1ns / 1ps

// Status frame receiver.
// Input channel (byte_valid/byte_ready/byte_item): one frame byte per
// transaction, byte 0 first, last_byte set on the final byte.
// Output channel (result_valid/result_ready/result_item): one transaction
// per frame, sent for the byte marked last_byte. status 0 is ok; on any
// other status every other field is zero.
// Throughput: one byte per cycle unless the input stage stalls. The CRC
// byte update and the field capture sit between the input stage register
// and the result register. A final byte is registered in the input stage,
// then its result in the result register.
// When the receiver stalls, a pending result stays in the result register
// and bytes of the next frame keep flowing; only a second final byte waits
// in the input stage until the result register is taken.
// Reset clears the byte count, reloads the CRC to 0xFFFF, drops the
// sequence handshake and empties both stages.
module status_frame_receiver
	import sfr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_ready,
	input  byte_item_t   byte_item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result_item
);

	logic               valid_s1;
	byte_item_t         item_s1;
	logic               adv;
	logic [POS_W-1:0]   pos_q;
	logic [15:0]        crc_q;
	logic [7:0]         store_q [STORE_DEPTH];
	logic               hs_q;
	logic [7:0]         last_seq_q;
	logic               res_valid_q;
	result_item_t       res_q;

	logic        len_ok, id_ok, seq_bad, crc_ok, seq_take;
	logic [7:0]  diff;
	logic [2:0]  status;
	result_item_t res_next;

	assign adv        = valid_s1 && !(item_s1.last_byte && res_valid_q && !result_ready);
	assign byte_ready = !valid_s1 || adv;

	assign len_ok  = (pos_q == POS_FINAL);
	assign id_ok   = (store_q[0] == FRAME_TYPE) && (store_q[1] == FRAME_VERSION);
	assign diff    = store_q[2] - last_seq_q;
	assign seq_bad = hs_q && ((diff == 8'd0) || (diff > SEQ_WINDOW));
	assign crc_ok  = (crc_q == {store_q[CRC_BYTES], item_s1.data_byte});
	assign seq_take = adv && item_s1.last_byte && len_ok && id_ok && !seq_bad;

	always_comb begin
		if (!len_ok)
			status = STATUS_BAD_LEN;
		else if (!id_ok)
			status = STATUS_BAD_ID;
		else if (seq_bad)
			status = STATUS_BAD_SEQ;
		else if (!crc_ok)
			status = STATUS_BAD_CRC;
		else
			status = STATUS_OK;

		res_next = '0;
		res_next.status = status;
		if (status == STATUS_OK) begin
			res_next.seq_number      = store_q[2];
			res_next.flag_bits       = store_q[3];
			res_next.time_seconds    = {store_q[4], store_q[5], store_q[6], store_q[7]};
			res_next.time_micros     = {store_q[8], store_q[9], store_q[10], store_q[11]};
			res_next.arm_position    = {store_q[12], store_q[13]};
			res_next.arm_speed       = {store_q[14], store_q[15]};
			res_next.arm_effort      = {store_q[16], store_q[17]};
			res_next.motor_current   = store_q[18];
			res_next.temperature_raw = store_q[19];
			res_next.supply_voltage  = store_q[20];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
			hs_q        <= 1'b0;
			last_seq_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (byte_ready)
				valid_s1 <= byte_valid;

			if (adv && item_s1.last_byte)
				res_valid_q <= 1'b1;
			else if (result_ready)
				res_valid_q <= 1'b0;

			if (adv) begin
				if (item_s1.last_byte) begin
					pos_q <= '0;
					crc_q <= CRC_INIT;
				end else begin
					if (pos_q < POS_W'(CRC_BYTES))
						crc_q <= crc16_update(crc_q, item_s1.data_byte);
					if (pos_q < POS_SAT)
						pos_q <= pos_q + POS_W'(1);
				end
			end

			if (seq_take) begin
				hs_q       <= 1'b1;
				last_seq_q <= store_q[2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			item_s1 <= byte_item;
		if (adv && item_s1.last_byte)
			res_q <= res_next;
		if (adv && !item_s1.last_byte && pos_q < POS_W'(STORE_DEPTH))
			store_q[pos_q[STORE_AW-1:0]] <= item_s1.data_byte;
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_SAT)
		else $error("byte count beyond saturation");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.last_byte) |=> (pos_q == '0) && (crc_q == CRC_INIT))
		else $error("count or crc not reloaded after frame end");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != STATUS_OK) |-> (res_q.seq_number == '0)
			&& (res_q.time_seconds == '0) && (res_q.supply_voltage == '0))
		else $error("fields not cleared on error status");

	a_hs_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(hs_q))
		else $error("handshake dropped");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> (res_valid_q && !result_ready && item_s1.last_byte))
		else $error("input stage stalled without full result register");

endmodule
